// ===== sv/ppf_pkg.sv =====
// shared constants, types and control structs of the particle engine
package ppf_pkg;

    // default number of particle slots
    localparam int NUM_PARTICLES_DEF = 4;

    // configuration register indexes
    localparam logic [1:0] CFG_ACTIVE_COUNT = 2'd0;
    localparam logic [1:0] CFG_WORLD_SIZE   = 2'd1;
    localparam logic [1:0] CFG_FORCE_GAIN   = 2'd2;
    localparam logic [1:0] CFG_MIN_DIST_SQ  = 2'd3;

    // configuration reset values
    localparam logic [2:0]  ACTIVE_COUNT_RST = 3'd3;
    localparam logic [9:0]  WORLD_SIZE_RST   = 10'd800;
    localparam logic [31:0] FORCE_GAIN_RST   = 32'd720575940;
    localparam logic [24:0] MIN_DIST_SQ_RST  = 25'd1048576;

    // request type codes
    localparam logic REQ_LOAD = 1'b0;
    localparam logic REQ_STEP = 1'b1;

    // fixed point: Q10.22 ports, Q24.40 internal
    localparam int POS_LSB = 18;
    localparam int POS_MSB = 49;
    localparam logic [63:0] MARGIN_Q40 = 64'd1099511628;
    localparam logic [62:0] SAT_MAG    = 63'h7FFF_FFFF_FFFF_FFFF;

    // divider widths
    localparam int DEN_W  = 59;
    localparam int QUOT_W = 64;

    typedef struct packed {
        logic        en;
        logic [31:0] a;
        logic [31:0] b;
    } t_mul_req;

    typedef struct packed {
        logic              start;
        logic [QUOT_W-1:0] num;
        logic [DEN_W-1:0]  den;
    } t_div_req;

    typedef struct packed {
        logic              busy;
        logic              done;
        logic [QUOT_W-1:0] quot;
    } t_div_rsp;

endpackage

// ===== sv/ppf_if.sv =====
// request and result channel interfaces of the particle engine
interface ppf_req_if;
    logic        valid;
    logic        ready;
    logic        req_type;
    logic [1:0]  particle_index;
    logic [31:0] load_x;
    logic [31:0] load_y;
    logic [19:0] frame_dt;

    modport source (
        output valid, req_type, particle_index, load_x, load_y, frame_dt,
        input  ready
    );
    modport sink (
        input  valid, req_type, particle_index, load_x, load_y, frame_dt,
        output ready
    );
endinterface

interface ppf_rsp_if;
    logic        valid;
    logic        ready;
    logic [1:0]  out_index;
    logic [31:0] out_x;
    logic [31:0] out_y;
    logic        last_flag;

    modport source (
        output valid, out_index, out_x, out_y, last_flag,
        input  ready
    );
    modport sink (
        input  valid, out_index, out_x, out_y, last_flag,
        output ready
    );
endinterface

// ===== sv/ppf_mul.sv =====
// shared 32x32 unsigned multiplier with registered product
module ppf_mul
    import ppf_pkg::*;
(
    input  logic        i_clk,
    input  t_mul_req    i_req,
    output logic [63:0] o_prod
);

    logic [63:0] r_prod;

    // product loads only when the sequencer issues an operation
    always_ff @(posedge i_clk) begin
        if (i_req.en) begin
            r_prod <= 64'(i_req.a) * 64'(i_req.b);
        end
    end

    assign o_prod = r_prod;

endmodule

// ===== sv/ppf_div.sv =====
// iterative restoring divider, one quotient bit per cycle
module ppf_div
    import ppf_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);

    localparam int CNT_W = $clog2(QUOT_W + 1);

    logic              r_busy;
    logic              r_done;
    logic [CNT_W-1:0]  r_cnt;
    logic [QUOT_W-1:0] r_quot;
    logic [DEN_W:0]    r_rem;
    logic [DEN_W-1:0]  r_den;
    logic [DEN_W:0]    n_shift;
    logic              n_ge;
    logic [DEN_W:0]    n_rem;

    // shift in the next numerator bit and try a subtract
    always_comb begin
        n_shift = {r_rem[DEN_W-1:0], r_quot[QUOT_W-1]};
        n_ge    = (n_shift >= {1'b0, r_den});
        n_rem   = n_ge ? (n_shift - {1'b0, r_den}) : n_shift;
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_req.start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= CNT_W'(QUOT_W);
        end else if (r_busy) begin
            r_cnt <= r_cnt - CNT_W'(1);
            if (r_cnt == CNT_W'(1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end else begin
            r_done <= 1'b0;
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_quot <= i_req.num;
            r_rem  <= '0;
            r_den  <= i_req.den;
        end else if (r_busy) begin
            r_quot <= {r_quot[QUOT_W-2:0], n_ge};
            r_rem  <= n_rem;
        end
    end

    assign o_rsp.busy = r_busy;
    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_quot;

endmodule

// ===== sv/particle_pair_force_euler_step_core.sv =====
// Particle engine top level: slot memories, frame sequencer and shared arithmetic.
// A load transaction writes its slot when accepted. A step transaction walks every ordered pair of
// active particles and then integrates each one. The step time is set by the shared
// one-bit-per-cycle divider, which runs twice per pair whose floored distance is nonzero,
// and by the shared 32x32 multiplier, which forms every square, gain product and dt product
// in turn. Each result waits in the output register while the receiver stalls, and the next
// particle's emit waits for it. The block takes no new transaction until the step's last
// result is in the output register; results leave through that register.
module particle_pair_force_euler_step_core
    import ppf_pkg::*;
#(
    parameter int NUM_PARTICLES = NUM_PARTICLES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    ppf_req_if.sink     i_req,
    ppf_rsp_if.source   o_rsp,
    input  logic        i_cfg_wr_en,
    input  logic [1:0]  i_cfg_index,
    input  logic [31:0] i_cfg_wdata
);

    localparam int IW = $clog2(NUM_PARTICLES);
    localparam int CW = $clog2(NUM_PARTICLES + 1);

    localparam logic signed [64:0] SAT_HI = $signed({2'b00, SAT_MAG});
    localparam logic signed [64:0] SAT_LO = -SAT_HI;

    // sequencer states
    localparam logic [4:0] S_IDLE      = 5'd0;
    localparam logic [4:0] S_PI_RD     = 5'd1;
    localparam logic [4:0] S_PI_LAT    = 5'd2;
    localparam logic [4:0] S_PJ_CHK    = 5'd3;
    localparam logic [4:0] S_PJ_LAT    = 5'd4;
    localparam logic [4:0] S_SQX       = 5'd5;
    localparam logic [4:0] S_SQY       = 5'd6;
    localparam logic [4:0] S_DSQ       = 5'd7;
    localparam logic [4:0] S_DIVX      = 5'd8;
    localparam logic [4:0] S_DIVX_WAIT = 5'd9;
    localparam logic [4:0] S_DIVY_WAIT = 5'd10;
    localparam logic [4:0] S_IN_RD     = 5'd11;
    localparam logic [4:0] S_IN_LAT    = 5'd12;
    localparam logic [4:0] S_MLO       = 5'd13;
    localparam logic [4:0] S_MHI       = 5'd14;
    localparam logic [4:0] S_MCMB      = 5'd15;
    localparam logic [4:0] S_MACC      = 5'd16;
    localparam logic [4:0] S_CLAMP     = 5'd17;
    localparam logic [4:0] S_EMIT      = 5'd18;

    function automatic logic signed [63:0] f_sat_add(
        input logic signed [63:0] a,
        input logic signed [63:0] b
    );
        logic signed [64:0] s;
        s = $signed({a[63], a}) + $signed({b[63], b});
        if (s > SAT_HI) begin
            return $signed({1'b0, SAT_MAG});
        end else if (s < SAT_LO) begin
            return -$signed({1'b0, SAT_MAG});
        end
        return $signed(s[63:0]);
    endfunction

    // configuration registers
    logic [2:0]  r_active;
    logic [9:0]  r_world;
    logic [31:0] r_gain;
    logic [24:0] r_min_dsq;

    // slot memories and valid bits
    logic [127:0] m_pos [NUM_PARTICLES];
    logic [127:0] m_vel [NUM_PARTICLES];
    logic [127:0] m_acc [NUM_PARTICLES];
    logic [NUM_PARTICLES-1:0] r_valid;
    logic [127:0] r_pos_rd;
    logic [127:0] r_vel_rd;
    logic [127:0] r_acc_rd;
    logic         r_rd_vld;

    // sequencer and datapath registers
    logic [4:0]  r_st;
    logic [CW-1:0] r_n;
    logic [CW-1:0] r_i;
    logic [CW-1:0] r_j;
    logic [1:0]  r_k;
    logic [19:0] r_dt;
    logic [31:0] r_xi, r_yi;
    logic [31:0] r_mx, r_my;
    logic        r_sx, r_sy;
    logic [42:0] r_dsq;
    logic signed [63:0] r_ax, r_ay;
    logic signed [63:0] r_px, r_py, r_vx, r_vy;
    logic [51:0] r_lo;
    logic        r_neg;
    logic signed [63:0] r_term;

    // output register
    logic        r_out_valid;
    logic [1:0]  r_out_index;
    logic [31:0] r_out_x, r_out_y;
    logic        r_out_last;

    // shared units
    t_mul_req    w_mul_req;
    logic [63:0] w_prod;
    t_div_req    w_div_req;
    t_div_rsp    w_div_rsp;

    ppf_mul u_mul (
        .i_clk  (i_clk),
        .i_req  (w_mul_req),
        .o_prod (w_prod)
    );

    ppf_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_rsp   (w_div_rsp)
    );

    // combinational helpers
    logic [CW-1:0]  w_n_eff;
    logic [IW-1:0]  w_rd_addr;
    logic [IW-1:0]  w_load_addr;
    logic           w_load_ok;
    logic [63:0]    w_pos_x_rd, w_pos_y_rd, w_vel_x_rd, w_vel_y_rd;
    logic [32:0]    w_dx, w_dy;
    logic [42:0]    w_dsq_sum, w_dsq_flr;
    logic signed [63:0] w_sel;
    logic [63:0]    w_mag;
    logic [84:0]    w_full;
    logic [62:0]    w_mag63;
    logic [63:0]    w_qterm;
    logic [63:0]    w_top;
    logic           w_req_fire;
    logic           w_emit_fire;
    logic           w_last_i;

    assign w_n_eff = ({29'b0, r_active} > 32'(NUM_PARTICLES)) ?
                     CW'(NUM_PARTICLES) : CW'(r_active);
    assign w_load_addr = IW'(i_req.particle_index);
    assign w_load_ok   = ({30'b0, i_req.particle_index} < 32'(NUM_PARTICLES));
    assign w_rd_addr   = (r_st == S_PJ_CHK) ? r_j[IW-1:0] : r_i[IW-1:0];
    assign w_req_fire  = i_req.valid && i_req.ready;
    assign w_emit_fire = (r_st == S_EMIT) && (!r_out_valid || o_rsp.ready);
    assign w_last_i    = ((r_i + CW'(1)) == r_n);

    // unwritten slots read as zero
    assign w_pos_x_rd = r_rd_vld ? r_pos_rd[127:64] : '0;
    assign w_pos_y_rd = r_rd_vld ? r_pos_rd[63:0]   : '0;
    assign w_vel_x_rd = r_rd_vld ? r_vel_rd[127:64] : '0;
    assign w_vel_y_rd = r_rd_vld ? r_vel_rd[63:0]   : '0;

    // pair differences against the latched self position
    assign w_dx = {1'b0, w_pos_x_rd[POS_MSB:POS_LSB]} - {1'b0, r_xi};
    assign w_dy = {1'b0, w_pos_y_rd[POS_MSB:POS_LSB]} - {1'b0, r_yi};

    // squared distance with floor
    assign w_dsq_sum = r_dsq + {1'b0, w_prod[63:22]};
    assign w_dsq_flr = (w_dsq_sum < {18'b0, r_min_dsq}) ? {18'b0, r_min_dsq} : w_dsq_sum;

    // signed force term from the divider quotient
    assign w_qterm = (r_st == S_DIVX_WAIT) ?
                     (r_sx ? (~w_div_rsp.quot + 64'd1) : w_div_rsp.quot) :
                     (r_sy ? (~w_div_rsp.quot + 64'd1) : w_div_rsp.quot);

    // operand of the current dt product
    always_comb begin
        unique case (r_k)
            2'd0:    w_sel = r_vx;
            2'd1:    w_sel = r_vy;
            2'd2:    w_sel = r_ax;
            default: w_sel = r_ay;
        endcase
    end
    assign w_mag   = w_sel[63] ? (~w_sel + 64'd1) : w_sel;
    assign w_full  = {1'b0, w_prod[51:0], 32'b0} + {33'b0, r_lo};
    assign w_mag63 = (w_full > {22'b0, SAT_MAG}) ? SAT_MAG : w_full[62:0];

    // clamp ceiling: world side in Q24.40, zero world acts as one
    assign w_top = {14'b0, ((r_world == 10'd0) ? 10'd1 : r_world), 40'b0};

    // multiplier operand selection
    always_comb begin
        w_mul_req = '0;
        unique case (r_st)
            S_SQX: begin
                w_mul_req = '{en: 1'b1, a: r_mx, b: r_mx};
            end
            S_SQY: begin
                w_mul_req = '{en: 1'b1, a: r_my, b: r_my};
            end
            S_DSQ: begin
                w_mul_req = '{en: 1'b1, a: r_mx, b: r_gain};
            end
            S_DIVX: begin
                w_mul_req = '{en: 1'b1, a: r_my, b: r_gain};
            end
            S_MLO: begin
                w_mul_req = '{en: 1'b1, a: w_mag[31:0], b: {12'b0, r_dt}};
            end
            S_MHI: begin
                w_mul_req = '{en: 1'b1, a: w_mag[63:32], b: {12'b0, r_dt}};
            end
            default: begin
                w_mul_req = '0;
            end
        endcase
    end

    // divider start: x term after the distance, y term when x finishes
    always_comb begin
        w_div_req.start = (r_st == S_DIVX) || ((r_st == S_DIVX_WAIT) && w_div_rsp.done);
        w_div_req.num   = w_prod;
        w_div_req.den   = {r_dsq, 16'b0};
    end

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active  <= ACTIVE_COUNT_RST;
            r_world   <= WORLD_SIZE_RST;
            r_gain    <= FORCE_GAIN_RST;
            r_min_dsq <= MIN_DIST_SQ_RST;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                CFG_ACTIVE_COUNT: r_active  <= i_cfg_wdata[2:0];
                CFG_WORLD_SIZE:   r_world   <= i_cfg_wdata[9:0];
                CFG_FORCE_GAIN:   r_gain    <= i_cfg_wdata;
                default:          r_min_dsq <= i_cfg_wdata[24:0];
            endcase
        end
    end

    // slot memories: registered read, one write port each
    always_ff @(posedge i_clk) begin
        r_pos_rd <= m_pos[w_rd_addr];
        r_vel_rd <= m_vel[w_rd_addr];
        r_acc_rd <= m_acc[w_rd_addr];
        if (r_st == S_IDLE && w_req_fire && i_req.req_type == REQ_LOAD && w_load_ok) begin
            m_pos[w_load_addr] <= {14'b0, i_req.load_x, 18'b0, 14'b0, i_req.load_y, 18'b0};
            m_vel[w_load_addr] <= '0;
        end else if (w_emit_fire) begin
            m_pos[r_i[IW-1:0]] <= {r_px, r_py};
            m_vel[r_i[IW-1:0]] <= {r_vx, r_vy};
        end
        if (r_st == S_PJ_CHK && r_j == r_n) begin
            m_acc[r_i[IW-1:0]] <= {r_ax, r_ay};
        end
    end

    // slot valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            r_rd_vld <= r_valid[w_rd_addr];
            if (r_st == S_IDLE && w_req_fire && i_req.req_type == REQ_LOAD && w_load_ok) begin
                r_valid[w_load_addr] <= 1'b1;
            end else if (w_emit_fire) begin
                r_valid[r_i[IW-1:0]] <= 1'b1;
            end
        end
    end

    // frame sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_IDLE;
            r_n  <= '0;
            r_i  <= '0;
            r_j  <= '0;
            r_k  <= '0;
        end else begin
            unique case (r_st)
                S_IDLE: begin
                    if (w_req_fire && i_req.req_type == REQ_STEP) begin
                        r_n <= w_n_eff;
                        r_i <= '0;
                        if (w_n_eff != '0) begin
                            r_st <= S_PI_RD;
                        end
                    end
                end
                S_PI_RD: begin
                    r_st <= S_PI_LAT;
                end
                S_PI_LAT: begin
                    r_j  <= '0;
                    r_st <= S_PJ_CHK;
                end
                S_PJ_CHK: begin
                    if (r_j == r_n) begin
                        if (w_last_i) begin
                            r_i  <= '0;
                            r_st <= S_IN_RD;
                        end else begin
                            r_i  <= r_i + CW'(1);
                            r_st <= S_PI_RD;
                        end
                    end else if (r_j == r_i) begin
                        r_j <= r_j + CW'(1);
                    end else begin
                        r_st <= S_PJ_LAT;
                    end
                end
                S_PJ_LAT: begin
                    r_st <= S_SQX;
                end
                S_SQX: begin
                    r_st <= S_SQY;
                end
                S_SQY: begin
                    r_st <= S_DSQ;
                end
                S_DSQ: begin
                    // coincident pair with no floor adds nothing
                    if (w_dsq_flr == '0) begin
                        r_j  <= r_j + CW'(1);
                        r_st <= S_PJ_CHK;
                    end else begin
                        r_st <= S_DIVX;
                    end
                end
                S_DIVX: begin
                    r_st <= S_DIVX_WAIT;
                end
                S_DIVX_WAIT: begin
                    if (w_div_rsp.done) begin
                        r_st <= S_DIVY_WAIT;
                    end
                end
                S_DIVY_WAIT: begin
                    if (w_div_rsp.done) begin
                        r_j  <= r_j + CW'(1);
                        r_st <= S_PJ_CHK;
                    end
                end
                S_IN_RD: begin
                    r_st <= S_IN_LAT;
                end
                S_IN_LAT: begin
                    r_k  <= '0;
                    r_st <= S_MLO;
                end
                S_MLO: begin
                    r_st <= S_MHI;
                end
                S_MHI: begin
                    r_st <= S_MCMB;
                end
                S_MCMB: begin
                    r_st <= S_MACC;
                end
                S_MACC: begin
                    r_k <= r_k + 2'd1;
                    r_st <= (r_k == 2'd3) ? S_CLAMP : S_MLO;
                end
                S_CLAMP: begin
                    r_st <= S_EMIT;
                end
                S_EMIT: begin
                    if (w_emit_fire) begin
                        if (w_last_i) begin
                            r_st <= S_IDLE;
                        end else begin
                            r_i  <= r_i + CW'(1);
                            r_st <= S_IN_RD;
                        end
                    end
                end
                default: begin
                    r_st <= S_IDLE;
                end
            endcase
        end
    end

    // arithmetic datapath registers
    always_ff @(posedge i_clk) begin
        unique case (r_st)
            S_IDLE: begin
                if (w_req_fire) begin
                    r_dt <= i_req.frame_dt;
                end
            end
            S_PI_LAT: begin
                r_xi <= w_pos_x_rd[POS_MSB:POS_LSB];
                r_yi <= w_pos_y_rd[POS_MSB:POS_LSB];
                r_ax <= '0;
                r_ay <= '0;
            end
            S_PJ_LAT: begin
                r_sx  <= w_dx[32];
                r_sy  <= w_dy[32];
                r_mx  <= w_dx[32] ? 32'(~w_dx + 33'd1) : w_dx[31:0];
                r_my  <= w_dy[32] ? 32'(~w_dy + 33'd1) : w_dy[31:0];
                r_dsq <= '0;
            end
            S_SQY: begin
                r_dsq <= {1'b0, w_prod[63:22]};
            end
            S_DSQ: begin
                r_dsq <= w_dsq_flr;
            end
            S_DIVX_WAIT: begin
                if (w_div_rsp.done) begin
                    r_ax <= f_sat_add(r_ax, $signed(w_qterm));
                end
            end
            S_DIVY_WAIT: begin
                if (w_div_rsp.done) begin
                    r_ay <= f_sat_add(r_ay, $signed(w_qterm));
                end
            end
            S_IN_LAT: begin
                r_px <= $signed(w_pos_x_rd);
                r_py <= $signed(w_pos_y_rd);
                r_vx <= $signed(w_vel_x_rd);
                r_vy <= $signed(w_vel_y_rd);
                r_ax <= $signed(r_acc_rd[127:64]);
                r_ay <= $signed(r_acc_rd[63:0]);
            end
            S_MLO: begin
                r_neg <= w_sel[63];
            end
            S_MHI: begin
                r_lo <= w_prod[51:0];
            end
            S_MCMB: begin
                r_term <= r_neg ? -$signed({1'b0, w_mag63}) : $signed({1'b0, w_mag63});
            end
            S_MACC: begin
                // position uses the old speed before the speed moves
                unique case (r_k)
                    2'd0:    r_px <= f_sat_add(r_px, r_term);
                    2'd1:    r_py <= f_sat_add(r_py, r_term);
                    2'd2:    r_vx <= f_sat_add(r_vx, r_term);
                    default: r_vy <= f_sat_add(r_vy, r_term);
                endcase
            end
            S_CLAMP: begin
                // each axis clamps on its own and stops on that axis
                if (r_px < 0) begin
                    r_px <= '0;
                    r_vx <= '0;
                end else if (r_px >= $signed(w_top)) begin
                    r_px <= $signed(w_top - MARGIN_Q40);
                    r_vx <= '0;
                end
                if (r_py < 0) begin
                    r_py <= '0;
                    r_vy <= '0;
                end else if (r_py >= $signed(w_top)) begin
                    r_py <= $signed(w_top - MARGIN_Q40);
                    r_vy <= '0;
                end
            end
            default: begin
            end
        endcase
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_emit_fire) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit_fire) begin
            r_out_index <= r_i[1:0];
            r_out_x     <= r_px[POS_MSB:POS_LSB];
            r_out_y     <= r_py[POS_MSB:POS_LSB];
            r_out_last  <= w_last_i;
        end
    end

    assign i_req.ready     = (r_st == S_IDLE);
    assign o_rsp.valid     = r_out_valid;
    assign o_rsp.out_index = r_out_index;
    assign o_rsp.out_x     = r_out_x;
    assign o_rsp.out_y     = r_out_y;
    assign o_rsp.last_flag = r_out_last;

endmodule

// ===== sv/ppf_chk.sv =====
// port-level checker for the particle engine, bound to the top level
module ppf_chk
    import ppf_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_req_valid,
    input logic        i_req_ready,
    input logic        i_req_type,
    input logic        i_rsp_valid,
    input logic        i_rsp_ready,
    input logic [1:0]  i_rsp_index,
    input logic [31:0] i_rsp_x,
    input logic [31:0] i_rsp_y,
    input logic        i_rsp_last
);

    // a load transaction never produces a result
    a_load_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req_valid && i_req_ready && i_req_type == REQ_LOAD) |=> !$rose(i_rsp_valid))
        else $error("result appeared after a load");

    // a step is still running while a non-final result waits
    a_busy_mid_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rsp_valid && !i_rsp_last) |-> !i_req_ready)
        else $error("request taken in the middle of a step");

    // a stalled result stays
    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rsp_valid && !i_rsp_ready) |=> i_rsp_valid)
        else $error("result dropped while stalled");

    // a stalled result keeps its payload
    a_rsp_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rsp_valid && !i_rsp_ready) |=>
            $stable({i_rsp_index, i_rsp_x, i_rsp_y, i_rsp_last}))
        else $error("result payload changed while stalled");

endmodule

bind particle_pair_force_euler_step_core ppf_chk u_ppf_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_req_valid (i_req.valid),
    .i_req_ready (i_req.ready),
    .i_req_type  (i_req.req_type),
    .i_rsp_valid (o_rsp.valid),
    .i_rsp_ready (o_rsp.ready),
    .i_rsp_index (o_rsp.out_index),
    .i_rsp_x     (o_rsp.out_x),
    .i_rsp_y     (o_rsp.out_y),
    .i_rsp_last  (o_rsp.last_flag)
);

// ===== verif/particle_pair_force_euler_step_core_tb.sv =====
// particle engine tb: directed and random loads and steps checked against a fixed-point predictor
`timescale 1ns / 1ps

module particle_pair_force_euler_step_core_tb;
    import ppf_pkg::*;

    localparam int NP = 4;
    localparam int WATCHDOG_LIMIT = 400000;

    typedef struct {
        logic        req_type;
        logic [1:0]  particle_index;
        logic [31:0] load_x;
        logic [31:0] load_y;
        logic [19:0] frame_dt;
    } frame_req_t;

    typedef struct {
        logic [1:0]  out_index;
        logic [31:0] out_x;
        logic [31:0] out_y;
        logic        last_flag;
    } pos_report_t;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_wr_en;
    logic [1:0] i_cfg_index;
    logic [31:0] i_cfg_wdata;

    ppf_req_if req_ch ();
    ppf_rsp_if rsp_ch ();

    particle_pair_force_euler_step_core #(.NUM_PARTICLES(NP)) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (req_ch.sink),
        .o_rsp      (rsp_ch.source),
        .i_cfg_wr_en(i_cfg_wr_en),
        .i_cfg_index(i_cfg_index),
        .i_cfg_wdata(i_cfg_wdata)
    );

    // predictor state
    logic [2:0]  m_active;
    logic [9:0]  m_world;
    logic [31:0] m_gain;
    logic [24:0] m_min_dsq;
    longint m_px[NP], m_py[NP], m_vx[NP], m_vy[NP], m_ax[NP], m_ay[NP];

    frame_req_t  pending_reqs[$];
    pos_report_t expected_pos[$];
    int error_count;
    int send_idle_pct, recv_idle_pct;
    int recv_hold;
    bit sim_done;
    int idle_cycles;
    bit req_fired;

    localparam longint SAT_POS = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam longint SAT_NEG = -64'sh7FFF_FFFF_FFFF_FFFF;

    // clock
    initial i_clk = 1'b0;
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    function automatic longint sat_sum(longint a, longint b);
        if (b > 0 && a > SAT_POS - b) return SAT_POS;
        if (b < 0 && a < SAT_NEG - b) return SAT_NEG;
        return a + b;
    endfunction

    function automatic longint sat_scale(longint v, longint unsigned dt);
        longint unsigned mag;
        longint unsigned r;
        mag = (v < 0) ? (64'd0 - longint'(v)) : v;
        if (dt != 0 && mag > longint'(SAT_POS) / dt) r = SAT_POS;
        else r = mag * dt;
        if (r > longint'(SAT_POS)) r = SAT_POS;
        return (v < 0) ? -longint'(r) : longint'(r);
    endfunction

    function automatic longint pull_term(longint d, longint unsigned denom);
        longint unsigned mag;
        longint unsigned q;
        mag = (d < 0) ? longint'(-d) : longint'(d);
        q = (mag * longint'(m_gain)) / denom;
        return (d < 0) ? -longint'(q) : longint'(q);
    endfunction

    task automatic clamp_to_world(inout longint p, inout longint v, inout longint a,
                                  input longint top);
        if (p < 0) begin
            p = 0; v = 0; a = 0;
        end else if (p >= top) begin
            p = top - longint'(MARGIN_Q40); v = 0; a = 0;
        end
    endtask

    // advance the particle model by one transaction, queue its reports
    task automatic predict_frame(input frame_req_t r);
        int n;
        longint unsigned world, dsq, mx, my, dt;
        longint top, xi, yi, dx, dy;
        pos_report_t rep;
        if (r.req_type == REQ_LOAD) begin
            m_px[r.particle_index] = longint'({32'd0, r.load_x}) <<< 18;
            m_py[r.particle_index] = longint'({32'd0, r.load_y}) <<< 18;
            m_vx[r.particle_index] = 0; m_vy[r.particle_index] = 0;
            m_ax[r.particle_index] = 0; m_ay[r.particle_index] = 0;
            return;
        end
        n = (m_active > NP) ? NP : m_active;
        dt = r.frame_dt;
        world = (m_world == 0) ? 1 : m_world;
        top = longint'(world << 40);
        // pairwise attraction from pre-step positions
        for (int i = 0; i < n; i++) begin
            xi = m_px[i] >>> 18;
            yi = m_py[i] >>> 18;
            for (int j = 0; j < n; j++) begin
                if (j == i) continue;
                dx = (m_px[j] >>> 18) - xi;
                dy = (m_py[j] >>> 18) - yi;
                mx = (dx < 0) ? -dx : dx;
                my = (dy < 0) ? -dy : dy;
                dsq = ((mx * mx) >> 22) + ((my * my) >> 22);
                if (dsq < m_min_dsq) dsq = m_min_dsq;
                if (dsq == 0) continue;
                m_ax[i] = sat_sum(m_ax[i], pull_term(dx, dsq << 16));
                m_ay[i] = sat_sum(m_ay[i], pull_term(dy, dsq << 16));
            end
        end
        // euler update and per-axis clamp
        for (int i = 0; i < n; i++) begin
            m_px[i] = sat_sum(m_px[i], sat_scale(m_vx[i], dt));
            m_py[i] = sat_sum(m_py[i], sat_scale(m_vy[i], dt));
            m_vx[i] = sat_sum(m_vx[i], sat_scale(m_ax[i], dt));
            m_vy[i] = sat_sum(m_vy[i], sat_scale(m_ay[i], dt));
            clamp_to_world(m_px[i], m_vx[i], m_ax[i], top);
            clamp_to_world(m_py[i], m_vy[i], m_ay[i], top);
            m_ax[i] = 0;
            m_ay[i] = 0;
            rep.out_index = i[1:0];
            rep.out_x = m_px[i][49:18];
            rep.out_y = m_py[i][49:18];
            rep.last_flag = (i == n - 1);
            expected_pos.insert(expected_pos.size(), rep);
        end
    endtask

    task automatic report_mismatch(input string msg);
        $display("mismatch at %0t: %s", $realtime, msg);
        error_count++;
    endtask

    // remember whether the offered transaction was taken at the last edge
    always @(posedge i_clk) begin
        req_fired <= i_rst_n && req_ch.valid && req_ch.ready;
    end

    // driver
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            req_ch.valid <= 1'b0;
        end else if (req_ch.valid && !req_fired) begin
            // hold the offered transaction
        end else begin
            if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                frame_req_t r;
                r = pending_reqs.pop_front();
                req_ch.valid          <= 1'b1;
                req_ch.req_type       <= r.req_type;
                req_ch.particle_index <= r.particle_index;
                req_ch.load_x         <= r.load_x;
                req_ch.load_y         <= r.load_y;
                req_ch.frame_dt       <= r.frame_dt;
            end else begin
                req_ch.valid <= 1'b0;
            end
        end
    end

    // receiver ready with random stalls and long hold-offs
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            rsp_ch.ready <= 1'b0;
        end else if (recv_hold > 0) begin
            recv_hold    <= recv_hold - 1;
            rsp_ch.ready <= 1'b0;
        end else begin
            rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // monitor: predict on accepted requests, check accepted results
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (req_ch.valid && req_ch.ready) begin
                frame_req_t r;
                r.req_type       = req_ch.req_type;
                r.particle_index = req_ch.particle_index;
                r.load_x         = req_ch.load_x;
                r.load_y         = req_ch.load_y;
                r.frame_dt       = req_ch.frame_dt;
                predict_frame(r);
            end
            if (rsp_ch.valid && rsp_ch.ready) begin
                pos_report_t e;
                if (expected_pos.size() == 0) begin
                    report_mismatch("unexpected position transaction");
                end else begin
                    e = expected_pos.pop_front();
                    if (rsp_ch.out_index !== e.out_index)
                        report_mismatch($sformatf("out_index %0d exp %0d",
                                        rsp_ch.out_index, e.out_index));
                    if (rsp_ch.out_x !== e.out_x)
                        report_mismatch($sformatf("out_x %h exp %h slot %0d",
                                        rsp_ch.out_x, e.out_x, e.out_index));
                    if (rsp_ch.out_y !== e.out_y)
                        report_mismatch($sformatf("out_y %h exp %h slot %0d",
                                        rsp_ch.out_y, e.out_y, e.out_index));
                    if (rsp_ch.last_flag !== e.last_flag)
                        report_mismatch($sformatf("last_flag %0d exp %0d",
                                        rsp_ch.last_flag, e.last_flag));
                end
            end
        end
    end

    // watchdog on cycles without any transaction
    always @(posedge i_clk) begin
        if (!i_rst_n || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT && !sim_done) begin
            $display("watchdog expired");
            $display("status: fail");
            $finish;
        end
    end

    function automatic frame_req_t make_load(int slot, logic [31:0] x, logic [31:0] y);
        frame_req_t r;
        r.req_type = REQ_LOAD;
        r.particle_index = slot[1:0];
        r.load_x = x;
        r.load_y = y;
        r.frame_dt = 20'($urandom);
        return r;
    endfunction

    function automatic frame_req_t make_step(logic [19:0] dt);
        frame_req_t r;
        r.req_type = REQ_STEP;
        r.particle_index = 2'($urandom);
        r.load_x = $urandom;
        r.load_y = $urandom;
        r.frame_dt = dt;
        return r;
    endfunction

    // append one transaction to the driver queue
    task automatic queue_req(input frame_req_t r);
        pending_reqs.insert(pending_reqs.size(), r);
    endtask

    // random position, mostly inside a small box so forces are noticeable
    function automatic logic [31:0] rand_pos();
        case ($urandom_range(9))
            0: return $urandom;
            1: return 32'hFFFF_FFFF;
            default: return (32'd300 + $urandom_range(200)) << 22 | ($urandom & 32'h3F_FFFF);
        endcase
    endfunction

    function automatic logic [19:0] rand_dt();
        case ($urandom_range(9))
            0: return 20'($urandom);
            1: return 20'hF_FFFF;
            2: return 20'd0;
            default: return 20'($urandom_range(20000, 1));
        endcase
    endfunction

    task automatic wait_drained();
        while (pending_reqs.size() > 0 || req_ch.valid || expected_pos.size() > 0)
            @(posedge i_clk);
        repeat (50) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= val;
        // model sees the write at the same edge as the block
        @(posedge i_clk);
        case (idx)
            CFG_ACTIVE_COUNT: m_active  = val[2:0];
            CFG_WORLD_SIZE:   m_world   = val[9:0];
            CFG_FORCE_GAIN:   m_gain    = val;
            CFG_MIN_DIST_SQ:  m_min_dsq = val[24:0];
        endcase
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b0;
    endtask

    // random phase: a random mix of loads and steps, mostly steps
    task automatic queue_random(input int count);
        for (int k = 0; k < count; k++) begin
            if ($urandom_range(3) == 0)
                queue_req(make_load($urandom_range(3), rand_pos(), rand_pos()));
            else
                queue_req(make_step(rand_dt()));
        end
    endtask

    initial begin
        error_count = 0;
        sim_done = 1'b0;
        recv_hold = 0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        idle_cycles = 0;
        i_rst_n = 1'b0;
        i_cfg_wr_en = 1'b0;
        i_cfg_index = CFG_ACTIVE_COUNT;
        i_cfg_wdata = '0;
        req_ch.valid = 1'b0;
        req_ch.req_type = REQ_LOAD;
        req_ch.particle_index = '0;
        req_ch.load_x = '0;
        req_ch.load_y = '0;
        req_ch.frame_dt = '0;
        rsp_ch.ready = 1'b0;
        m_active = ACTIVE_COUNT_RST;
        m_world = WORLD_SIZE_RST;
        m_gain = FORCE_GAIN_RST;
        m_min_dsq = MIN_DIST_SQ_RST;
        for (int i = 0; i < NP; i++) begin
            m_px[i] = 0; m_py[i] = 0; m_vx[i] = 0; m_vy[i] = 0; m_ax[i] = 0; m_ay[i] = 0;
        end
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: reset defaults, coincident particles, field extremes
        queue_req(make_step(20'd1000));
        queue_req(make_load(0, 32'd400 << 22, 32'd400 << 22));
        queue_req(make_load(1, 32'd400 << 22, 32'd400 << 22));
        queue_req(make_load(2, 32'd402 << 22, 32'd399 << 22));
        queue_req(make_step(20'd5000));
        queue_req(make_step(20'hF_FFFF));
        queue_req(make_load(3, 32'hFFFF_FFFF, 32'h0));
        queue_req(make_load(2, 32'h0, 32'hFFFF_FFFF));
        queue_req(make_step(20'd0));
        queue_req(make_step(20'd1));
        wait_drained();

        // four active, tiny world, max gain, zero distance floor
        write_reg(CFG_ACTIVE_COUNT, 32'd4);
        write_reg(CFG_WORLD_SIZE, 32'd1);
        write_reg(CFG_FORCE_GAIN, 32'hFFFF_FFFF);
        write_reg(CFG_MIN_DIST_SQ, 32'd0);
        queue_req(make_load(0, 32'h0010_0000, 32'h0020_0000));
        queue_req(make_load(1, 32'h0010_0000, 32'h0020_0000));
        queue_req(make_load(2, 32'h0030_0000, 32'h0008_0000));
        queue_req(make_load(3, 32'h0000_0001, 32'h003F_FFFF));
        queue_req(make_step(20'd100));
        queue_req(make_step(20'd3000));
        wait_drained();

        // zero world, one active, then above-range and zero active counts
        write_reg(CFG_WORLD_SIZE, 32'd0);
        write_reg(CFG_ACTIVE_COUNT, 32'd1);
        queue_req(make_step(20'd7));
        wait_drained();
        write_reg(CFG_ACTIVE_COUNT, 32'd7);
        write_reg(CFG_WORLD_SIZE, 32'd1023);
        write_reg(CFG_FORCE_GAIN, 32'd0);
        write_reg(CFG_MIN_DIST_SQ, 32'd16777216);
        queue_req(make_step(20'd50));
        wait_drained();
        write_reg(CFG_ACTIVE_COUNT, 32'd0);
        queue_req(make_step(20'd50));
        queue_req(make_load(1, 32'd10 << 22, 32'd20 << 22));
        wait_drained();

        // random phase one: sender idles less, receiver more
        write_reg(CFG_ACTIVE_COUNT, 32'd3);
        write_reg(CFG_WORLD_SIZE, 32'd800);
        write_reg(CFG_FORCE_GAIN, 32'd720575940);
        write_reg(CFG_MIN_DIST_SQ, 32'd1048576);
        send_idle_pct = 21;
        recv_idle_pct = 48;
        for (int s = 0; s < 4; s++)
            queue_req(make_load(s, rand_pos(), rand_pos()));
        queue_random(40);
        // long receiver hold-off while requests keep coming
        recv_hold = 3000;
        wait_drained();

        // random phase two: roles swapped, strong forces
        write_reg(CFG_ACTIVE_COUNT, 32'd4);
        write_reg(CFG_FORCE_GAIN, $urandom);
        write_reg(CFG_MIN_DIST_SQ, $urandom_range(16777216));
        write_reg(CFG_WORLD_SIZE, $urandom_range(1023, 1));
        send_idle_pct = 48;
        recv_idle_pct = 21;
        queue_random(40);
        wait_drained();

        // random phase three: no idling, two particles
        write_reg(CFG_ACTIVE_COUNT, 32'd2);
        write_reg(CFG_MIN_DIST_SQ, $urandom);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        queue_random(40);
        wait_drained();

        sim_done = 1'b1;
        if (error_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end
endmodule
